>>> rtl/core/rgd_pkg.sv
// ----------------------------------------------------------------------------
// rgd_pkg
// widths, types and the output saturation helper shared by the block and its
// checker
// ----------------------------------------------------------------------------
package rgd_pkg;

    localparam int DATA_W   = 32;
    localparam int KW       = 8;
    localparam int IDX_W    = 16;
    localparam int COEF_W   = 21;
    localparam int NUM_AX   = 3;
    localparam int CFG_W    = NUM_AX * COEF_W;
    localparam int CFG_IDX_W = 2;
    localparam int KP_W     = COEF_W + KW;
    localparam int G_W      = KP_W + 2;
    localparam int OPA_W    = DATA_W + 1;
    localparam int PROD_W   = OPA_W + G_W;
    localparam int FRAC_W   = 16;
    localparam int RND_W    = PROD_W - FRAC_W;
    localparam int SUM_W    = RND_W + 2;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X = 2'd0,
        REG_ROW_Y = 2'd1,
        REG_ROW_Z = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic                     clip;
        logic signed [DATA_W-1:0] value;
    } t_sat;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic t_sat sat_data(input logic signed [SUM_W-1:0] v);
        t_sat res;
        res.clip  = !((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]));
        res.value = res.clip ? (v[SUM_W-1] ? DATA_MIN : DATA_MAX) : v[DATA_W-1:0];
        return res;
    endfunction

endpackage

>>> rtl/core/reciprocal_gradient_divergence.sv
// ----------------------------------------------------------------------------
// reciprocal_gradient_divergence
// spectral gradient or divergence of one reciprocal-space point per transaction
// ----------------------------------------------------------------------------
// usage:
//   input channel i_valid/o_ready carries one point: action, destination index,
//   wave indices and complex data. output channel o_valid/i_ready returns one
//   result per point, in order. rows of the matrix are written through
//   i_cfg_we/i_cfg_index/i_cfg_data while the block is idle.
// a point passes the four register stages in order; o_valid is the valid bit
//   of the last stage.
// throughput: 1 point per cycle while i_ready stays high, set by the four
//   register stages (g rows, data by g multiply, rounding, sum and saturation).
// reset clears the matrix rows and all stage valid bits.
// when i_ready is low the output holds; earlier stages keep filling bubbles
//   and o_ready falls only once all four stages hold a point.
// ----------------------------------------------------------------------------
module reciprocal_gradient_divergence
    import rgd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_action,
    input  logic [IDX_W-1:0]         i_dest_index,
    input  logic signed [KW-1:0]     i_kx,
    input  logic signed [KW-1:0]     i_ky,
    input  logic signed [KW-1:0]     i_kz,
    input  logic signed [DATA_W-1:0] i_x_re,
    input  logic signed [DATA_W-1:0] i_x_im,
    input  logic signed [DATA_W-1:0] i_y_re,
    input  logic signed [DATA_W-1:0] i_y_im,
    input  logic signed [DATA_W-1:0] i_z_re,
    input  logic signed [DATA_W-1:0] i_z_im,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [IDX_W-1:0]         o_out_index,
    output logic signed [DATA_W-1:0] o_out_x_re,
    output logic signed [DATA_W-1:0] o_out_x_im,
    output logic signed [DATA_W-1:0] o_out_y_re,
    output logic signed [DATA_W-1:0] o_out_y_im,
    output logic signed [DATA_W-1:0] o_out_z_re,
    output logic signed [DATA_W-1:0] o_out_z_im,
    output logic                     o_saturated
);

    logic [CFG_W-1:0] r_row [NUM_AX];

    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    // stage 1
    logic                     r_div1;
    logic [IDX_W-1:0]         r_idx1;
    logic signed [G_W-1:0]    r_g  [NUM_AX];
    logic signed [OPA_W-1:0]  r_ap [NUM_AX];
    logic signed [OPA_W-1:0]  r_aq [NUM_AX];
    logic signed [G_W-1:0]    n_g  [NUM_AX];
    logic signed [OPA_W-1:0]  n_ap [NUM_AX];
    logic signed [OPA_W-1:0]  n_aq [NUM_AX];

    // stage 2
    logic                     r_div2;
    logic [IDX_W-1:0]         r_idx2;
    logic signed [PROD_W-1:0] r_pp [NUM_AX];
    logic signed [PROD_W-1:0] r_pq [NUM_AX];

    // stage 3
    logic                     r_div3;
    logic [IDX_W-1:0]         r_idx3;
    logic signed [RND_W-1:0]  r_rp [NUM_AX];
    logic signed [RND_W-1:0]  r_rq [NUM_AX];
    logic signed [RND_W-1:0]  n_rp [NUM_AX];
    logic signed [RND_W-1:0]  n_rq [NUM_AX];

    // stage 4
    logic [IDX_W-1:0]         r_out_index;
    logic signed [DATA_W-1:0] r_out [2*NUM_AX];
    logic                     r_sat;
    logic signed [DATA_W-1:0] n_out [2*NUM_AX];
    logic                     n_sat;

    logic signed [KW-1:0]     w_k  [NUM_AX];
    logic signed [DATA_W-1:0] w_re [NUM_AX];
    logic signed [DATA_W-1:0] w_im [NUM_AX];
    logic signed [KP_W-1:0]   w_kp [NUM_AX][NUM_AX];

    assign w_k  = '{i_kx, i_ky, i_kz};
    assign w_re = '{i_x_re, i_y_re, i_z_re};
    assign w_im = '{i_x_im, i_y_im, i_z_im};

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '{default: '0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROW_X: r_row[0] <= i_cfg_data;
                REG_ROW_Y: r_row[1] <= i_cfg_data;
                REG_ROW_Z: r_row[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // g = M*k and operand selection
    always_comb begin
        for (int r = 0; r < NUM_AX; r++) begin
            for (int j = 0; j < NUM_AX; j++) begin
                w_kp[r][j] = $signed(r_row[r][j*COEF_W +: COEF_W]) * w_k[j];
            end
            n_g[r] = G_W'(w_kp[r][0]) + G_W'(w_kp[r][1]) + G_W'(w_kp[r][2]);
            if (i_action) begin
                n_ap[r] = OPA_W'(w_im[r]);
                n_aq[r] = OPA_W'(w_re[r]);
            end else begin
                n_ap[r] = OPA_W'(i_x_im);
                n_aq[r] = -OPA_W'(i_x_re);
            end
        end
    end

    // round half toward plus infinity
    always_comb begin
        logic signed [PROD_W-1:0] tp;
        logic signed [PROD_W-1:0] tq;
        for (int a = 0; a < NUM_AX; a++) begin
            tp      = r_pp[a] + $signed(ROUND_HALF);
            tq      = r_pq[a] + $signed(ROUND_HALF);
            n_rp[a] = tp[PROD_W-1:FRAC_W];
            n_rq[a] = tq[PROD_W-1:FRAC_W];
        end
    end

    // divergence sum, -i and zero y/z for a divergence point, saturate every field
    always_comb begin
        logic signed [SUM_W-1:0] sre;
        logic signed [SUM_W-1:0] sim;
        t_sat s [2*NUM_AX];
        sre = SUM_W'(r_rq[0]) + SUM_W'(r_rq[1]) + SUM_W'(r_rq[2]);
        sim = SUM_W'(r_rp[0]) + SUM_W'(r_rp[1]) + SUM_W'(r_rp[2]);
        for (int a = 0; a < NUM_AX; a++) begin
            s[2*a]   = sat_data(SUM_W'(r_rp[a]));
            s[2*a+1] = sat_data(SUM_W'(r_rq[a]));
        end
        if (r_div3) begin
            s[0] = sat_data(sim);
            s[1] = sat_data(-sre);
            for (int i = 2; i < 2*NUM_AX; i++) begin
                s[i] = '0;
            end
        end
        n_sat = 1'b0;
        for (int i = 0; i < 2*NUM_AX; i++) begin
            n_out[i] = s[i].value;
            n_sat    = n_sat | s[i].clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_div1 <= i_action;
            r_idx1 <= i_dest_index;
            r_g    <= n_g;
            r_ap   <= n_ap;
            r_aq   <= n_aq;
        end
        if (en2) begin
            r_div2 <= r_div1;
            r_idx2 <= r_idx1;
            for (int a = 0; a < NUM_AX; a++) begin
                r_pp[a] <= r_ap[a] * r_g[a];
                r_pq[a] <= r_aq[a] * r_g[a];
            end
        end
        if (en3) begin
            r_div3 <= r_div2;
            r_idx3 <= r_idx2;
            r_rp   <= n_rp;
            r_rq   <= n_rq;
        end
        if (en4) begin
            r_out_index <= r_idx3;
            r_out       <= n_out;
            r_sat       <= n_sat;
        end
    end

    assign o_valid     = r_v4;
    assign o_out_index = r_out_index;
    assign o_out_x_re  = r_out[0];
    assign o_out_x_im  = r_out[1];
    assign o_out_y_re  = r_out[2];
    assign o_out_y_im  = r_out[3];
    assign o_out_z_re  = r_out[4];
    assign o_out_z_im  = r_out[5];
    assign o_saturated = r_sat;

endmodule

>>> rtl/core/rgd_checker.sv
// ----------------------------------------------------------------------------
// rgd_checker
// port-level checks on the gradient/divergence block, bound to its module
// ----------------------------------------------------------------------------
module rgd_checker
    import rgd_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_ready,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic [IDX_W-1:0]         o_out_index,
    input logic signed [DATA_W-1:0] o_out_x_re,
    input logic signed [DATA_W-1:0] o_out_x_im,
    input logic signed [DATA_W-1:0] o_out_y_re,
    input logic signed [DATA_W-1:0] o_out_y_im,
    input logic signed [DATA_W-1:0] o_out_z_re,
    input logic signed [DATA_W-1:0] o_out_z_im,
    input logic                     o_saturated
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // stalled transaction holds its index, x fields and saturation flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_index)
            && $stable(o_out_x_re) && $stable(o_out_x_im) && $stable(o_saturated))
        else $error("stalled output changed");

    // backpressure only while the output holds a point and the sink stalls
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("o_ready low with room in pipeline");

    // a clip leaves a limit value in some field
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            o_out_x_re == DATA_MAX || o_out_x_re == DATA_MIN ||
            o_out_x_im == DATA_MAX || o_out_x_im == DATA_MIN ||
            o_out_y_re == DATA_MAX || o_out_y_re == DATA_MIN ||
            o_out_y_im == DATA_MAX || o_out_y_im == DATA_MIN ||
            o_out_z_re == DATA_MAX || o_out_z_re == DATA_MIN ||
            o_out_z_im == DATA_MAX || o_out_z_im == DATA_MIN)
        else $error("saturated flag without limit value");

endmodule

bind reciprocal_gradient_divergence rgd_checker u_rgd_checker (.*);
